@@ hdl/ticket_fifo_with_key_purge_top_defines.svh @@
// Assertion macros shared by the checker of the ticket queue.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef TICKET_FIFO_WITH_KEY_PURGE_TOP_DEFINES_SVH
`define TICKET_FIFO_WITH_KEY_PURGE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TFKP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfkp assertion failed");

// Next-cycle implication, disabled during reset.
`define TFKP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfkp assertion failed");

`endif

@@ hdl/tfkp_pkg.sv @@
// Package of the ticket queue: sizes, request and status codes, item types.
// Holds the key folding function. Depends on nothing.
package tfkp_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int KEY_BYTES   = 8;
  localparam int TICKET_BITS = 16;

  localparam logic [2:0] REQ_ENQ    = 3'd0;
  localparam logic [2:0] REQ_DEQ    = 3'd1;
  localparam logic [2:0] REQ_LOOKUP = 3'd2;
  localparam logic [2:0] REQ_COUNT  = 3'd3;
  localparam logic [2:0] REQ_PURGE  = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] name_key;
    logic [63:0] entry_payload;
    logic [15:0] wanted_ticket;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ticket;
    logic [63:0] key_out;
    logic [63:0] payload_out;
    logic [4:0]  tally;
  } out_item_t;

  // Folds lower-case letters to upper case; bytes past the key length read as zero.
  function automatic logic [63:0] fold_key(input logic [63:0] k);
    logic [63:0] r;
    logic [7:0]  b;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h61 && b <= 8'h7A) begin
        b = b - 8'h20;
      end
      if (i < KEY_BYTES) begin
        r[8*i +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/tfkp_front.sv @@
// Front end of the ticket queue: accepts requests, folds the key and holds
// them in a two-entry command queue for the back end. Uses tfkp_pkg.
module tfkp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tfkp_pkg::in_item_t in_item,
  output logic               cmd_empty,
  input  logic               cmd_pop,
  output tfkp_pkg::in_item_t cmd_item
);

  tfkp_pkg::in_item_t q_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               do_push, do_pop;
  tfkp_pkg::in_item_t folded;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_empty = (cnt_r == 2'd0);
  assign cmd_item  = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && !cmd_empty;

  always_comb begin
    folded          = in_item;
    folded.name_key = tfkp_pkg::fold_key(in_item.name_key);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/tfkp_back.sv @@
// Back end of the ticket queue: the entry cells, ticket counter, request
// execution, iterative purge and the result register. Uses tfkp_pkg.
module tfkp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  tfkp_pkg::in_item_t  cmd_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tfkp_pkg::out_item_t out_item
);

  localparam int D = tfkp_pkg::DEPTH;
  localparam int IW = tfkp_pkg::IDX_W;
  localparam int OW = tfkp_pkg::OCC_W;
  localparam int TB = tfkp_pkg::TICKET_BITS;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  logic [63:0] key_r [D];
  logic [63:0] pay_r [D];
  logic [TB-1:0] tkt_r [D];
  logic [63:0] key_nxt [D];
  logic [63:0] pay_nxt [D];
  logic [TB-1:0] tkt_nxt [D];
  logic [D-1:0] match_r, match_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [TB-1:0] last_r, last_nxt, tkt_next;
  logic [OW-1:0] tally_r, tally_nxt;
  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  tfkp_pkg::out_item_t res_r, res_nxt;

  logic slot_free, take;
  logic [D-1:0] hit, kmatch;
  logic [IW-1:0] hit_idx, m_idx, rm_idx;
  logic hit_any, do_rm;

  assign slot_free = !out_valid_r || out_pop;
  assign take      = (state_r == ST_RUN) && !cmd_empty && slot_free;
  assign cmd_pop   = take;
  assign out_empty = !out_valid_r;
  assign out_item  = res_r;

  always_comb begin
    tkt_next = last_r + 1'b1;
    if (tkt_next == '0) tkt_next = TB'(1);
  end

  always_comb begin
    hit_idx = '0;
    m_idx   = '0;
    for (int i = 0; i < D; i++) begin
      hit[i]    = (OW'(i) < occ_r) && (tkt_r[i] == cmd_item.wanted_ticket[TB-1:0]);
      kmatch[i] = (OW'(i) < occ_r) && (key_r[i] == cmd_item.name_key);
    end
    for (int i = D - 1; i >= 0; i--) begin
      if (hit[i])     hit_idx = IW'(i);
      if (match_r[i]) m_idx   = IW'(i);
    end
    hit_any = |hit;
  end

  always_comb begin
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    tkt_nxt       = tkt_r;
    match_nxt     = match_r;
    occ_nxt       = occ_r;
    last_nxt      = last_r;
    tally_nxt     = tally_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_pop;
    res_nxt       = res_r;
    do_rm         = 1'b0;
    rm_idx        = '0;

    if (take) begin
      res_nxt       = '0;
      out_valid_nxt = 1'b1;
      case (cmd_item.req_type)
        tfkp_pkg::REQ_ENQ: begin
          if (occ_r >= OW'(D)) begin
            res_nxt.status = tfkp_pkg::ST_FULL;
          end else begin
            last_nxt = tkt_next;
            key_nxt[occ_r[IW-1:0]] = cmd_item.name_key;
            pay_nxt[occ_r[IW-1:0]] = cmd_item.entry_payload;
            tkt_nxt[occ_r[IW-1:0]] = tkt_next;
            occ_nxt = occ_r + 1'b1;
            res_nxt.ticket = 16'(tkt_next);
          end
        end
        tfkp_pkg::REQ_DEQ: begin
          if (occ_r == '0) begin
            res_nxt.status = tfkp_pkg::ST_EMPTY;
          end else begin
            res_nxt.ticket      = 16'(tkt_r[0]);
            res_nxt.key_out     = key_r[0];
            res_nxt.payload_out = pay_r[0];
            do_rm   = 1'b1;
            occ_nxt = occ_r - 1'b1;
          end
        end
        tfkp_pkg::REQ_LOOKUP: begin
          if (hit_any) begin
            res_nxt.ticket      = 16'(tkt_r[hit_idx]);
            res_nxt.key_out     = key_r[hit_idx];
            res_nxt.payload_out = pay_r[hit_idx];
          end else begin
            res_nxt.status = tfkp_pkg::ST_EMPTY;
          end
        end
        tfkp_pkg::REQ_COUNT: begin
          res_nxt.tally = 5'(occ_r);
        end
        tfkp_pkg::REQ_PURGE: begin
          // The result is written once the last matching cell is gone.
          out_valid_nxt = 1'b0;
          match_nxt     = kmatch;
          tally_nxt     = '0;
          state_nxt     = ST_PURGE;
        end
        tfkp_pkg::REQ_CLEAR: begin
          occ_nxt = '0;
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_PURGE) begin
      if (|match_r) begin
        do_rm     = 1'b1;
        rm_idx    = m_idx;
        occ_nxt   = occ_r - 1'b1;
        tally_nxt = tally_r + 1'b1;
      end else begin
        res_nxt       = '0;
        res_nxt.tally = 5'(tally_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_RUN;
      end
    end

    if (do_rm) begin
      for (int i = 0; i < D - 1; i++) begin
        if (IW'(i) >= rm_idx) begin
          key_nxt[i]   = key_r[i+1];
          pay_nxt[i]   = pay_r[i+1];
          tkt_nxt[i]   = tkt_r[i+1];
          match_nxt[i] = match_r[i+1];
        end
      end
      match_nxt[D-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
    tkt_r <= tkt_nxt;
    res_r <= res_nxt;
    match_r <= match_nxt;
    tally_r <= tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      last_r      <= '0;
      state_r     <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      last_r      <= last_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/ticket_fifo_with_key_purge_top.sv @@
// Ticket queue with purge by key: top level.
// Depends on tfkp_pkg, tfkp_front and tfkp_back.
//
// Usage: requests enter through a queue-style port. A transaction is
// accepted on a rising edge with in_push high and in_full low. Results
// leave through a second queue-style port: the oldest result sits on
// out_item while out_empty is low and is taken on an edge with out_pop high.
// Every request yields exactly one result, in request order.
// The front end folds the key and buffers up to two requests, so the
// sender keeps pushing while the back end is busy or the result waits.
// Enqueue, dequeue, lookup, count and clear show their result in the cycle
// after the back end takes them, one request per cycle while no purge runs
// and the receiver takes results. Purge scans the cell chain, removing one
// matching entry per cycle; it writes its result once no match is left,
// and the back end takes no new request until then.
// If the receiver stalls, the result register holds and the back end
// stops; the front queue then fills and raises in_full.
// Reset empties the queue and restarts tickets at 1; clear empties it
// but keeps the ticket counter. Entry cells are not cleared at reset.
module ticket_fifo_with_key_purge_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tfkp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tfkp_pkg::out_item_t out_item
);

  // Command queue between the front and back ends.
  logic               cmd_empty;
  logic               cmd_pop;
  tfkp_pkg::in_item_t cmd_item;

  tfkp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_item  (cmd_item)
  );

  tfkp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_item  (cmd_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

@@ hdl/tfkp_checker.sv @@
// Port-level checker of the ticket queue and its bind to the top level.
// Depends on tfkp_pkg and ticket_fifo_with_key_purge_top_defines.svh.
`include "ticket_fifo_with_key_purge_top_defines.svh"

module tfkp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input tfkp_pkg::out_item_t out_item
);

  // A held result stays put until it is taken.
  `TFKP_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_item))
  // The status code is never the unused value.
  `TFKP_ASSERT_IMP(a_status, !out_empty, out_item.status != 2'd3)
  // A refused enqueue issues no ticket and carries a zero tally.
  `TFKP_ASSERT_IMP(a_full, !out_empty && out_item.status == tfkp_pkg::ST_FULL,
    out_item.ticket == '0 && out_item.tally == '0)
  // A count or purge never exceeds the queue depth.
  `TFKP_ASSERT_IMP(a_tally, !out_empty, out_item.tally <= 5'(tfkp_pkg::DEPTH))

endmodule

bind ticket_fifo_with_key_purge_top tfkp_checker u_tfkp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

@@ dv/tb_ticket_fifo_with_key_purge_top.sv @@
// Self-checking testbench for the ticket queue with purge by key.
// Depends on tfkp_pkg and ticket_fifo_with_key_purge_top; a local model predicts each result.
module tb_ticket_fifo_with_key_purge_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 810;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  tfkp_pkg::in_item_t  in_item;
  logic                out_empty;
  logic                out_pop;
  tfkp_pkg::out_item_t out_item;

  ticket_fifo_with_key_purge_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // The shadow copy of the queue contents, oldest entry at index 0.
  logic [63:0] shadow_key [tfkp_pkg::DEPTH];
  logic [63:0] shadow_pay [tfkp_pkg::DEPTH];
  logic [15:0] shadow_tkt [tfkp_pkg::DEPTH];
  int          shadow_occ;
  logic [15:0] shadow_last_tkt;

  // Results that the block still owes us, oldest first.
  tfkp_pkg::out_item_t pending_results[$];
  tfkp_pkg::out_item_t last_pred;
  int                  accepted;

  int mismatches;
  int results_seen;
  int cycles;
  int purges_removing;
  int full_rejects;
  bit stimulus_done;
  bit long_hold;

  // Directed rows: the request and, where obvious, the result it must give.
  typedef struct {
    tfkp_pkg::in_item_t  req;
    bit                  has_golden;
    tfkp_pkg::out_item_t golden;
  } directed_row_t;
  directed_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Folds lower-case ASCII bytes of a key to upper case.
  function automatic logic [63:0] upcase_key(logic [63:0] k);
    logic [63:0] r;
    logic [7:0]  b;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b inside {[8'h61:8'h7A]}) begin
        b = b - 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

  // Drops the entry at position idx and closes the gap, keeping order.
  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < shadow_occ; i++) begin
      shadow_key[i] = shadow_key[i+1];
      shadow_pay[i] = shadow_pay[i+1];
      shadow_tkt[i] = shadow_tkt[i+1];
    end
    shadow_occ--;
  endfunction

  // Applies one request to the shadow queue and returns the result the block owes.
  function automatic tfkp_pkg::out_item_t queue_response(tfkp_pkg::in_item_t rq);
    tfkp_pkg::out_item_t res;
    logic [63:0]         k;
    int                  i;
    res = '0;
    k = upcase_key(rq.name_key);
    case (rq.req_type)
      tfkp_pkg::REQ_ENQ: begin
        if (shadow_occ >= tfkp_pkg::DEPTH) begin
          res.status = tfkp_pkg::ST_FULL;
          full_rejects++;
        end else begin
          shadow_last_tkt = shadow_last_tkt + 16'd1;
          if (shadow_last_tkt == 16'd0) begin
            shadow_last_tkt = 16'd1;
          end
          shadow_key[shadow_occ] = k;
          shadow_pay[shadow_occ] = rq.entry_payload;
          shadow_tkt[shadow_occ] = shadow_last_tkt;
          shadow_occ++;
          res.ticket = shadow_last_tkt;
        end
      end
      tfkp_pkg::REQ_DEQ: begin
        if (shadow_occ == 0) begin
          res.status = tfkp_pkg::ST_EMPTY;
        end else begin
          res.ticket = shadow_tkt[0];
          res.key_out = shadow_key[0];
          res.payload_out = shadow_pay[0];
          drop_entry(0);
        end
      end
      tfkp_pkg::REQ_LOOKUP: begin
        res.status = tfkp_pkg::ST_EMPTY;
        for (i = 0; i < shadow_occ; i++) begin
          if (shadow_tkt[i] == rq.wanted_ticket) begin
            res.status = tfkp_pkg::ST_OK;
            res.ticket = shadow_tkt[i];
            res.key_out = shadow_key[i];
            res.payload_out = shadow_pay[i];
            break;
          end
        end
      end
      tfkp_pkg::REQ_COUNT: res.tally = 5'(shadow_occ);
      tfkp_pkg::REQ_PURGE: begin
        i = 0;
        while (i < shadow_occ) begin
          if (shadow_key[i] == k) begin
            drop_entry(i);
            res.tally++;
          end else begin
            i++;
          end
        end
        if (res.tally != 0) begin
          purges_removing++;
        end
      end
      tfkp_pkg::REQ_CLEAR: shadow_occ = 0;
      default: ;
    endcase
    return res;
  endfunction

  // Flips the case of random letters so purge sees mixed-case spellings.
  function automatic logic [63:0] scramble_case(logic [63:0] k);
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] inside {[8'h41:8'h5A], [8'h61:8'h7A]} && $urandom_range(0, 1)) begin
        k[8*i + 5] = ~k[8*i + 5];
      end
    end
    return k;
  endfunction

  // A small pool of keys makes purge hits common.
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(0, 5))
      0: k = 64'h0000_0000_4E41_4E41;
      1: k = 64'h4F4C_4F4C_4F4C_4F4C;
      2: k = 64'h6162_6364_6566_6768;
      3: k = 64'h7A7A_7A7A_0000_0000;
      4: k = {$urandom(), $urandom()};
      default: k = 64'h5A41_5A41_5A41_5A41;
    endcase
    return scramble_case(k);
  endfunction

  function automatic tfkp_pkg::in_item_t random_request();
    tfkp_pkg::in_item_t rq;
    int unsigned        roll;
    rq.name_key = pick_key();
    rq.entry_payload = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      rq.req_type = tfkp_pkg::REQ_ENQ;
    end else if (roll < 60) begin
      rq.req_type = tfkp_pkg::REQ_DEQ;
    end else if (roll < 75) begin
      rq.req_type = tfkp_pkg::REQ_LOOKUP;
    end else if (roll < 82) begin
      rq.req_type = tfkp_pkg::REQ_COUNT;
    end else if (roll < 94) begin
      rq.req_type = tfkp_pkg::REQ_PURGE;
    end else if (roll < 97) begin
      rq.req_type = tfkp_pkg::REQ_CLEAR;
    end else begin
      rq.req_type = 3'($urandom_range(6, 7));
    end
    // Mostly ask for tickets near the counter so lookups hit live entries.
    if ($urandom_range(0, 3) != 0) begin
      rq.wanted_ticket = shadow_last_tkt - 16'($urandom_range(0, 17));
    end else begin
      rq.wanted_ticket = 16'($urandom());
    end
    return rq;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [63:0] k, logic [63:0] p,
                                  logic [15:0] w, bit known, tfkp_pkg::out_item_t g);
    directed_row_t row;
    row.req = '{req_type: op, name_key: k, entry_payload: p, wanted_ticket: w};
    row.has_golden = known;
    row.golden = g;
    directed_rows.push_back(row);
  endfunction

  // Offers one request and returns once the block has accepted it.
  task automatic offer_request(tfkp_pkg::in_item_t rq);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= rq;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Predicts and records expectations on every accepted transaction.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      last_pred = queue_response(in_item);
      pending_results.push_back(last_pred);
      accepted++;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    tfkp_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %h", out_item);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_item.status != want.status || out_item.ticket != want.ticket ||
            out_item.key_out != want.key_out || out_item.payload_out != want.payload_out ||
            out_item.tally != want.tally) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st=%0d tk=%0d key=%h pay=%h tally=%0d",
                     want.status, want.ticket, want.key_out, want.payload_out, want.tally);
            $display("          actual   st=%0d tk=%0d key=%h pay=%h tally=%0d",
                     out_item.status, out_item.ticket, out_item.key_out,
                     out_item.payload_out, out_item.tally);
          end
        end
      end
    end
  end

  // Receiver: random stalls between results, plus one long hold-off.
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        // Holding off lets the block fill up and push back on the sender.
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (out_pop && !out_empty) begin
        gap = $urandom_range(0, 3);
        if (gap != 0 && !stimulus_done) begin
          out_pop <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    tfkp_pkg::out_item_t z;
    tfkp_pkg::out_item_t g;
    tfkp_pkg::in_item_t  rq;
    int                  wait_cycles;
    int                  acc_before;
    in_push = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    shadow_occ = 0;
    shadow_last_tkt = '0;
    accepted = 0;
    mismatches = 0;
    results_seen = 0;
    purges_removing = 0;
    full_rejects = 0;
    stimulus_done = 1'b0;
    long_hold = 1'b0;
    z = '0;

    // Directed part: empty cases, extremes, case folding, every request code.
    g = z; g.status = tfkp_pkg::ST_EMPTY;
    add_row(tfkp_pkg::REQ_DEQ, '0, '0, 16'd1, 1'b1, g);
    add_row(tfkp_pkg::REQ_LOOKUP, '0, '0, 16'd1, 1'b1, g);
    add_row(tfkp_pkg::REQ_COUNT, '0, '0, '0, 1'b1, z);
    add_row(tfkp_pkg::REQ_PURGE, '1, '0, '0, 1'b1, z);
    g = z; g.ticket = 16'd1;
    add_row(tfkp_pkg::REQ_ENQ, 64'h6162_6378_797A_6061, '1, '0, 1'b1, g);
    add_row(tfkp_pkg::REQ_ENQ, '1, '0, '1, 1'b0, z);
    add_row(tfkp_pkg::REQ_ENQ, 64'h4142_4358_595A_6061, 64'h1, '0, 1'b0, z);
    add_row(tfkp_pkg::REQ_LOOKUP, '0, '0, 16'd0, 1'b1,
            '{status: tfkp_pkg::ST_EMPTY, default: '0});
    add_row(tfkp_pkg::REQ_LOOKUP, '0, '0, 16'd2, 1'b0, z);
    add_row(tfkp_pkg::REQ_LOOKUP, '0, '0, 16'hFFFF, 1'b0, z);
    add_row(tfkp_pkg::REQ_PURGE, 64'h4142_4378_797A_6041, '0, '0, 1'b0, z);
    add_row(3'd6, '1, '1, '1, 1'b1, z);
    add_row(3'd7, '0, '0, '0, 1'b1, z);
    add_row(tfkp_pkg::REQ_DEQ, '0, '0, '0, 1'b0, z);
    for (int i = 0; i < 17; i++) begin
      add_row(tfkp_pkg::REQ_ENQ, 64'(i), 64'(i * 3), '0, 1'b0, z);
    end
    add_row(tfkp_pkg::REQ_COUNT, '0, '0, '0, 1'b0, z);
    add_row(tfkp_pkg::REQ_CLEAR, '0, '0, '0, 1'b1, z);
    add_row(tfkp_pkg::REQ_COUNT, '0, '0, '0, 1'b1, z);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      acc_before = accepted;
      offer_request(directed_rows[r].req);
      wait (accepted != acc_before);
      if (directed_rows[r].has_golden && last_pred != directed_rows[r].golden) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("directed row %0d: model gives %h, table says %h",
                   r, last_pred, directed_rows[r].golden);
        end
      end
    end

    // Random part; the long receiver hold-off lands early in it.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 40) begin
        long_hold = 1'b1;
      end
      rq = random_request();
      offer_request(rq);
    end

    // A closing burst of enqueues and lookups against live tickets.
    for (int n = 0; n < 60; n++) begin
      rq = random_request();
      if (n % 3 != 2) begin
        rq.req_type = tfkp_pkg::REQ_ENQ;
      end else begin
        rq.req_type = tfkp_pkg::REQ_LOOKUP;
      end
      offer_request(rq);
    end
    in_push <= 1'b0;
    stimulus_done = 1'b1;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);

    $display("ran %0d results with %0d purges that removed entries and %0d full rejects,",
             results_seen, purges_removing, full_rejects);
    $display("including a long receiver stall that filled the block and held off the sender");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
